[rtl/core/ese_pkg.sv]
// Shared types, constants and reset values for the encoder speed estimator.
package ese_pkg;

  localparam int CountBits     = 16;
  localparam int TickRateHz    = 10000;
  localparam int SampleRateHz  = 1000;
  localparam int RpmPerQuarter = 3840;

  localparam logic [14:0] LineCountRst = 15'd1024;
  localparam logic [31:0] TimeoutRst   = 32'd23440;
  localparam logic [15:0] GainRst      = 16'd4118;
  localparam logic [23:0] EnterRst     = 24'd10240;
  localparam logic [23:0] LeaveRst     = 24'd7680;

  localparam logic [2:0] RegLineCount = 3'd0;
  localparam logic [2:0] RegTimeout   = 3'd1;
  localparam logic [2:0] RegFastGain  = 3'd2;
  localparam logic [2:0] RegSlowGain  = 3'd3;
  localparam logic [2:0] RegEnter     = 3'd4;
  localparam logic [2:0] RegLeave     = 3'd5;

  // Controller commands to the datapath.
  typedef struct packed {
    logic tick;     // apply tick update
    logic load;     // latch sample, set up divides
    logic div_step; // one restoring divide step on both dividers
    logic filt;     // run both filters
    logic finish;   // hysteresis and result register
  } ese_cmd_t;

  typedef struct packed {
    logic div_done;
  } ese_stat_t;

endpackage

[rtl/core/encoder_speed_estimator_top.sv]
// A tick request updates the tick state on acceptance and gives no result.
// A sample request's result becomes valid once 64 radix-2 divide steps on two
// shared-clock restoring dividers, the filter and the hysteresis have run.
// Throughput: one tick per cycle while idle with no result waiting; a sample only after the last is done.
// Reset (rst, synchronous) restores register defaults and clears the estimator state.
// Top level: stream ports, APB register file, controller and datapath.
module encoder_speed_estimator_top #(
  parameter int COUNT_BITS     = ese_pkg::CountBits,
  parameter int TICK_RATE_HZ   = ese_pkg::TickRateHz,
  parameter int SAMPLE_RATE_HZ = ese_pkg::SampleRateHz
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,  // count[15:0], dir_up[16], zeros
  input  logic         s_tuser,  // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,  // speed, fast_speed, slow_speed, fast_selected, stopped
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [14:0] line_count;
  logic [31:0] zero_speed_timeout;
  logic [15:0] fast_filter_gain, slow_filter_gain;
  logic [23:0] enter_fast_level, leave_fast_level;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count         <= ese_pkg::LineCountRst;
      zero_speed_timeout <= ese_pkg::TimeoutRst;
      fast_filter_gain   <= ese_pkg::GainRst;
      slow_filter_gain   <= ese_pkg::GainRst;
      enter_fast_level   <= ese_pkg::EnterRst;
      leave_fast_level   <= ese_pkg::LeaveRst;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        ese_pkg::RegLineCount: line_count         <= pwdata[14:0];
        ese_pkg::RegTimeout:   zero_speed_timeout <= pwdata;
        ese_pkg::RegFastGain:  fast_filter_gain   <= pwdata[15:0];
        ese_pkg::RegSlowGain:  slow_filter_gain   <= pwdata[15:0];
        ese_pkg::RegEnter:     enter_fast_level   <= pwdata[23:0];
        ese_pkg::RegLeave:     leave_fast_level   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      ese_pkg::RegLineCount: prdata = {17'b0, line_count};
      ese_pkg::RegTimeout:   prdata = zero_speed_timeout;
      ese_pkg::RegFastGain:  prdata = {16'b0, fast_filter_gain};
      ese_pkg::RegSlowGain:  prdata = {16'b0, slow_filter_gain};
      ese_pkg::RegEnter:     prdata = {8'b0, enter_fast_level};
      ese_pkg::RegLeave:     prdata = {8'b0, leave_fast_level};
      default:               prdata = '0;
    endcase
  end

  ese_pkg::ese_cmd_t  cmd;
  ese_pkg::ese_stat_t stat;
  logic [31:0] speed, fast_speed, slow_speed;
  logic        fast_selected, stopped;

  ese_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .s_kind(s_tuser),
    .m_tvalid, .m_tready, .stat, .cmd
  );

  ese_dp #(
    .COUNT_BITS(COUNT_BITS), .TICK_RATE_HZ(TICK_RATE_HZ),
    .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
  ) u_dp (
    .clk, .rst, .cmd, .stat,
    .count(s_tdata[15:0]), .dir_up(s_tdata[16]),
    .line_count, .zero_speed_timeout, .fast_filter_gain, .slow_filter_gain,
    .enter_fast_level, .leave_fast_level,
    .m_tready, .m_tvalid,
    .speed, .fast_speed, .slow_speed, .fast_selected, .stopped
  );

  assign m_tdata = {6'b0, stopped, fast_selected, slow_speed, fast_speed, speed};

endmodule

[rtl/core/ese_ctrl.sv]
// Sequencer for the encoder speed estimator: tick, load, divide, filter, finish.
module ese_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               s_kind,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  ese_pkg::ese_stat_t stat,
  output ese_pkg::ese_cmd_t  cmd
);

  typedef enum logic [4:0] {
    IDLE = 5'b00001,
    DIV  = 5'b00010,
    FILT = 5'b00100,
    FIN  = 5'b01000,
    HOLD = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   acc;

  // input waits while a result is held and not taken
  assign s_tready = (state == IDLE) && (!m_tvalid || m_tready);
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (acc && !s_kind) begin
          cmd.tick = 1'b1;
        end else if (acc) begin
          cmd.load   = 1'b1;
          state_next = DIV;
        end
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = FILT;
      end
      FILT: begin
        cmd.filt   = 1'b1;
        state_next = FIN;
      end
      FIN: begin
        cmd.finish = 1'b1;
        state_next = HOLD;
      end
      HOLD: state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= IDLE;
    else     state <= state_next;
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !s_tready) else $error("accept while busy");
  a_fin_after_filt: assert property (@(posedge clk) disable iff (rst)
    cmd.filt |=> cmd.finish) else $error("finish missing");

endmodule

[rtl/core/ese_dp.sv]
// Datapath: tick state, two serial dividers, low-pass filters, hysteresis.
module ese_dp #(
  parameter int COUNT_BITS     = ese_pkg::CountBits,
  parameter int TICK_RATE_HZ   = ese_pkg::TickRateHz,
  parameter int SAMPLE_RATE_HZ = ese_pkg::SampleRateHz
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ese_pkg::ese_cmd_t     cmd,
  output ese_pkg::ese_stat_t    stat,
  input  logic [15:0]           count,
  input  logic                  dir_up,
  input  logic [14:0]           line_count,
  input  logic [31:0]           zero_speed_timeout,
  input  logic [15:0]           fast_filter_gain,
  input  logic [15:0]           slow_filter_gain,
  input  logic [23:0]           enter_fast_level,
  input  logic [23:0]           leave_fast_level,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [31:0]           speed,
  output logic [31:0]           fast_speed,
  output logic [31:0]           slow_speed,
  output logic                  fast_selected,
  output logic                  stopped
);

  localparam int CB = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam logic [63:0] FastK = 64'(SAMPLE_RATE_HZ) * 64'(ese_pkg::RpmPerQuarter);
  localparam logic [63:0] SlowK = 64'(TICK_RATE_HZ) * 64'(ese_pkg::RpmPerQuarter);
  localparam logic [31:0] Ones  = 32'hFFFF_FFFF;

  logic [15:0] cnt;
  logic [16:0] lines;
  logic [15:0] prev_tick_count, prev_sample_count;
  logic        moving_forward, anchor_seen, fast_mode;
  logic [31:0] tick_counter, edge_period, idle_period, idle_ticks;
  logic signed [31:0] fast_filter_out, slow_filter_out;

  assign cnt   = (CB == 16) ? count : (count & 16'((17'd1 << CB) - 17'd1));
  assign lines = (line_count == '0) ? 17'd1 : {2'b0, line_count};

  function automatic logic signed [18:0] unwrap(input logic [15:0] a,
                                                input logic [15:0] b,
                                                input logic [16:0] l);
    logic signed [18:0] d, l2;
    d  = 19'($signed({3'b0, a})) - 19'($signed({3'b0, b}));
    l2 = $signed({1'b0, l, 1'b0});
    if (d > l2)       unwrap = d - (l2 <<< 1);
    else if (d < -l2) unwrap = d + (l2 <<< 1);
    else              unwrap = d;
  endfunction

  logic signed [18:0] dtick;
  assign dtick = unwrap(cnt, prev_tick_count, lines);

  logic [31:0] tc_inc, it_inc;
  assign tc_inc = (tick_counter == Ones) ? Ones : tick_counter + 32'd1;
  assign it_inc = (idle_ticks == Ones) ? Ones : idle_ticks + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_tick_count <= '0;
      moving_forward  <= 1'b1;
      anchor_seen     <= 1'b1;
      tick_counter    <= '0;
      edge_period     <= Ones;
      idle_period     <= Ones;
      idle_ticks      <= '0;
    end else if (cmd.tick) begin
      prev_tick_count <= cnt;
      if (dtick != '0) begin
        if (moving_forward != dir_up) begin
          edge_period <= Ones;
          anchor_seen <= 1'b0;
        end else if (!anchor_seen) begin
          anchor_seen <= 1'b1;
        end else begin
          edge_period <= tc_inc;
        end
        moving_forward <= dir_up;
        idle_period    <= '0;
        tick_counter   <= '0;
        idle_ticks     <= '0;
      end else begin
        tick_counter <= tc_inc;
        idle_period  <= tc_inc;
        idle_ticks   <= it_inc;
      end
    end
  end

  // Sample setup: fast dividend is magnitude*K + den/2, slow is K + den/2, each quotient in 64 bits.
  logic signed [18:0] dsamp;
  logic [17:0]        dmag;
  logic [31:0]        period;
  logic [48:0]        sden;
  logic [63:0]        fnum, snum;
  assign dsamp  = unwrap(cnt, prev_sample_count, lines);
  assign dmag   = dsamp[18] ? 18'(-dsamp) : 18'(dsamp);
  assign period = (idle_period > edge_period) ? idle_period : edge_period;
  assign sden   = 49'(lines) * 49'(period);
  assign fnum   = 64'(dmag) * FastK + 64'(lines >> 1);
  assign snum   = SlowK + 64'(sden >> 1);

  logic [63:0] fq, sq;
  logic [63:0] fr, sr;
  logic [48:0] fden, sdenr;
  logic [6:0]  step;
  logic        fneg, sneg, slow_zero, stop_r;
  logic [64:0] ftry, stry;

  assign ftry = {fr[62:0], fq[63]} - {16'b0, fden};
  assign stry = {sr[62:0], sq[63]} - {16'b0, sdenr};
  assign stat.div_done = (step == 7'd63);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_sample_count <= cnt;
      fq <= fnum; fr <= '0; fden <= 49'(lines);
      sq <= snum; sr <= '0; sdenr <= sden;
      fneg <= dsamp[18];
      sneg <= !moving_forward;
      stop_r <= idle_ticks > zero_speed_timeout;
      slow_zero <= (idle_ticks > zero_speed_timeout) || period == '0 || period == Ones;
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + 7'd1;
      if (!ftry[64]) begin fr <= ftry[63:0]; fq <= {fq[62:0], 1'b1}; end
      else begin fr <= {fr[62:0], fq[63]}; fq <= {fq[62:0], 1'b0}; end
      if (!stry[64]) begin sr <= stry[63:0]; sq <= {sq[62:0], 1'b1}; end
      else begin sr <= {sr[62:0], sq[63]}; sq <= {sq[62:0], 1'b0}; end
    end
    if (rst) prev_sample_count <= '0;
  end

  function automatic logic signed [31:0] sat_mag(input logic [63:0] m, input logic neg);
    if (m > 64'h7FFF_FFFF) sat_mag = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else                   sat_mag = neg ? -$signed(m[31:0]) : $signed(m[31:0]);
  endfunction

  function automatic logic signed [31:0] lowpass(input logic signed [31:0] prev,
                                                 input logic signed [31:0] x,
                                                 input logic [15:0] g);
    logic signed [50:0] acc;
    logic signed [34:0] y;
    acc = $signed({1'b0, g}) * x + $signed(18'd65536 - {2'b0, g}) * prev + 51'sd32768;
    y = 35'(acc >>> 16);
    if (y > 35'sh7FFF_FFFF)       lowpass = 32'sh7FFF_FFFF;
    else if (y < -35'sh8000_0000) lowpass = 32'sh8000_0000;
    else                          lowpass = y[31:0];
  endfunction

  logic signed [31:0] fraw, sraw, slow_abs_src;
  logic [32:0] sabs;
  assign fraw = sat_mag(fq, fneg);
  assign sraw = slow_zero ? 32'sd0 : sat_mag(sq, sneg);
  assign slow_abs_src = slow_filter_out;
  assign sabs = slow_abs_src[31] ? 33'(-$signed({slow_abs_src[31], slow_abs_src}))
                                 : {1'b0, slow_abs_src};

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_filter_out <= '0;
      slow_filter_out <= '0;
      fast_mode       <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cmd.filt) begin
        fast_filter_out <= lowpass(fast_filter_out, fraw, fast_filter_gain);
        slow_filter_out <= lowpass(slow_filter_out, sraw, slow_filter_gain);
      end
      if (cmd.finish) begin
        if (sabs > {9'b0, enter_fast_level} && !fast_mode) fast_mode <= 1'b1;
        else if (sabs < {9'b0, leave_fast_level} && fast_mode) fast_mode <= 1'b0;
        m_tvalid <= 1'b1;
      end
    end
  end

  assign speed         = fast_mode ? fast_filter_out : slow_filter_out;
  assign fast_speed    = fast_filter_out;
  assign slow_speed    = slow_filter_out;
  assign fast_selected = fast_mode;
  assign stopped       = stop_r;

endmodule
